// ----- design/stk_pkg.sv -----
// stk_pkg: shared constants, types and bit-gather functions of the seed to key block
// depends on nothing; used by every module of the block
`default_nettype none

package stk_pkg;

  localparam int unsigned WordWidth  = 32;
  localparam int unsigned CountWidth = 7;
  localparam int unsigned IdxWidth   = 4;

  typedef logic [WordWidth-1:0]  word_t;
  typedef logic [CountWidth-1:0] count_t;
  typedef logic [IdxWidth-1:0]   idx_t;

  localparam count_t CountBias = count_t'(31);

  localparam word_t MixTable [16] = '{
    32'h14FA3579, 32'h27CD3964, 32'h1777FE32, 32'h9931AF12,
    32'h75DB3A49, 32'h19294CAA, 32'hFF18CD76, 32'h0788236D,
    32'h5A6F7CBB, 32'h7A992254, 32'hADFD5414, 32'h343CFBCB,
    32'hC2F51639, 32'h6A6D5813, 32'h3729FF68, 32'h22A2C751
  };

  // sequencer controls to the shift-xor unit
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } ctrl_t;

  // table select: bit 0 is the msb, then bits 1, 2, 9
  function automatic idx_t mix_index(input word_t s);
    mix_index = {s[0], s[1], s[2], s[9]};
  endfunction

  // step count, 31 to 126
  function automatic count_t step_count(input word_t s);
    count_t raw;
    raw = {s[0], 1'b0, s[9], s[1], s[11], s[2], s[5]};
    step_count = raw + CountBias;
  endfunction

endpackage

`default_nettype wire

// ----- design/stk_seq.sv -----
// stk_seq: sequencer that loads a seed, counts shift-xor steps and hands off the key
// depends on stk_pkg
`default_nettype none

module stk_seq (
  input  wire            clk,
  input  wire            rst,
  input  wire            seed_valid,
  input  stk_pkg::word_t seed,
  input  wire            key_valid,
  input  wire            key_ready,
  output logic           busy,
  output stk_pkg::ctrl_t ctrl
);
  import stk_pkg::*;

  count_t cnt;

  always_comb begin
    ctrl.load   = seed_valid && !busy;
    ctrl.step   = busy && (cnt != '0);
    // result leaves only when the output register is free
    ctrl.finish = busy && (cnt == '0) && (!key_valid || key_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else begin
      if (ctrl.load) begin
        busy <= 1'b1;
        cnt  <= step_count(seed);
      end else if (ctrl.step) begin
        cnt <= cnt - count_t'(1);
      end else if (ctrl.finish) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/stk_step.sv -----
// stk_step: shared shift-xor unit holding the working word and the selected table word
// depends on stk_pkg
`default_nettype none

module stk_step (
  input  wire            clk,
  input  stk_pkg::ctrl_t ctrl,
  input  stk_pkg::word_t seed,
  output stk_pkg::word_t work
);
  import stk_pkg::*;

  word_t mix;
  word_t work_next;

  // double mod 2^32, fold in the table word when the old top bit was set
  always_comb begin
    work_next = {work[WordWidth-2:0], 1'b0} ^ (work[WordWidth-1] ? mix : '0);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      work <= seed;
      mix  <= MixTable[mix_index(seed)];
    end else if (ctrl.step) begin
      work <= work_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/seed_to_key_shift_xor.sv -----
// seed_to_key_shift_xor: a seed is run through step count shift-xor steps to its key,
// where step count = 31..126 set by seed bits; one shift-xor per cycle in stk_step.
// the key then waits for a free output register; seed_ready is low while a seed is
// worked, and a finished key waits in the output register while the next seed starts.
// reset (rst, synchronous) clears the sequencer and key_valid; no clearing pass.
// depends on stk_pkg, stk_seq, stk_step
`default_nettype none

module seed_to_key_shift_xor (
  input  wire            clk,
  input  wire            rst,
  input  wire            seed_valid,
  output logic           seed_ready,
  input  stk_pkg::word_t seed,
  output logic           key_valid,
  input  wire            key_ready,
  output stk_pkg::word_t key
);
  import stk_pkg::*;

  ctrl_t ctrl;
  logic  busy;
  word_t work;

  assign seed_ready = !busy;

  stk_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .seed_valid (seed_valid),
    .seed       (seed),
    .key_valid  (key_valid),
    .key_ready  (key_ready),
    .busy       (busy),
    .ctrl       (ctrl)
  );

  stk_step u_step (
    .clk  (clk),
    .ctrl (ctrl),
    .seed (seed),
    .work (work)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      key_valid <= 1'b0;
    end else if (ctrl.finish) begin
      key_valid <= 1'b1;
    end else if (key_ready) begin
      key_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      key <= work;
    end
  end

endmodule

`default_nettype wire

// ----- design/stk_chk.sv -----
// stk_chk: port-level checker for seed_to_key_shift_xor, bound to the top level
// depends on stk_pkg
`default_nettype none

module stk_chk (
  input wire            clk,
  input wire            rst,
  input wire            seed_valid,
  input wire            seed_ready,
  input stk_pkg::word_t seed,
  input wire            key_valid,
  input wire            key_ready,
  input stk_pkg::word_t key
);

  // a waiting seed beat holds
  a_seed_hold: assert property (@(posedge clk) disable iff (rst)
    seed_valid && !seed_ready |=> seed_valid && $stable(seed))
    else $error("seed beat changed while waiting");

  // a stalled key beat holds
  a_key_hold: assert property (@(posedge clk) disable iff (rst)
    key_valid && !key_ready |=> key_valid && $stable(key))
    else $error("key beat changed while stalled");

  // no second seed while one is worked
  a_busy_after_seed: assert property (@(posedge clk) disable iff (rst)
    seed_valid && seed_ready |=> !seed_ready)
    else $error("seed taken while busy");

  // at least 31 steps per seed
  a_min_steps: assert property (@(posedge clk) disable iff (rst)
    seed_valid && seed_ready |-> ##31 !seed_ready)
    else $error("seed finished in too few cycles");

  // a new key frees the input side at the same edge
  a_key_frees_input: assert property (@(posedge clk) disable iff (rst)
    $rose(key_valid) |-> seed_ready)
    else $error("key shown while still busy");

endmodule

bind seed_to_key_shift_xor stk_chk u_stk_chk (
  .clk        (clk),
  .rst        (rst),
  .seed_valid (seed_valid),
  .seed_ready (seed_ready),
  .seed       (seed),
  .key_valid  (key_valid),
  .key_ready  (key_ready),
  .key        (key)
);

`default_nettype wire

// ----- dv/seed_to_key_checker.sv -----
// seed_to_key_checker: watches the seed and key channels, predicts each key and compares
// depends on stk_pkg for the word type; instantiated beside the block by the test top
`timescale 1ns / 1ps

module seed_to_key_checker (
  input  wire            clk,
  input  wire            rst,
  input  wire            seed_valid,
  input  wire            seed_ready,
  input  stk_pkg::word_t seed,
  input  wire            key_valid,
  input  wire            key_ready,
  input  stk_pkg::word_t key,
  output int             errors,
  output int             pending,
  output int             checked
);

  import stk_pkg::word_t;

  localparam int unsigned RoundBias = 31;

  localparam word_t MixWords [16] = '{
    32'h14FA3579, 32'h27CD3964, 32'h1777FE32, 32'h9931AF12,
    32'h75DB3A49, 32'h19294CAA, 32'hFF18CD76, 32'h0788236D,
    32'h5A6F7CBB, 32'h7A992254, 32'hADFD5414, 32'h343CFBCB,
    32'hC2F51639, 32'h6A6D5813, 32'h3729FF68, 32'h22A2C751
  };

  word_t keys_due [$];
  word_t seeds_due [$];

  initial begin
    errors  = 0;
    pending = 0;
    checked = 0;
  end

  function automatic word_t predict_key(input word_t s);
    int unsigned rounds;
    logic [3:0]  pick;
    word_t       w;
    word_t       mix;
    rounds = RoundBias + {25'd0, s[0], 1'b0, s[9], s[1], s[11], s[2], s[5]};
    pick   = {s[0], s[1], s[2], s[9]};
    mix    = MixWords[pick];
    w      = s;
    for (int unsigned i = 0; i < rounds; i++) begin
      if (w[31]) begin
        w = (w << 1) ^ mix;
      end else begin
        w = w << 1;
      end
    end
    return w;
  endfunction

  task automatic report_mismatch(input string what, input word_t s, input word_t got,
                                 input word_t want);
    $display("[%0t] key mismatch: %s seed %08h key %08h expected %08h",
             $realtime, what, s, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (seed_valid && seed_ready) begin
        keys_due.push_back(predict_key(seed));
        seeds_due.push_back(seed);
      end
      if (key_valid && key_ready) begin
        if (keys_due.size() == 0) begin
          report_mismatch("beat with nothing due,", 32'h0, key, 32'h0);
        end else begin
          word_t want;
          word_t from;
          want = keys_due.pop_front();
          from = seeds_due.pop_front();
          if (key !== want) report_mismatch("field key,", from, key, want);
          checked++;
        end
      end
      pending = keys_due.size();
    end
  end

endmodule

// ----- dv/seed_to_key_shift_xor_test.sv -----
// seed_to_key_shift_xor_test: drives directed and random seeds with random gaps and stalls
// depends on stk_pkg, the seed_to_key_shift_xor block and seed_to_key_checker
`timescale 1ns / 1ps

module seed_to_key_shift_xor_test;

  import stk_pkg::word_t;

  localparam int RandomSeeds = 1350;
  localparam int BlockLen    = 150;
  localparam int DrainCycles = 160;
  localparam int CycleLimit  = 1000000;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  seed_valid = 1'b0;
  word_t seed = '0;
  logic  key_ready = 1'b0;
  wire   seed_ready;
  wire   key_valid;
  word_t key;

  int    errors;
  int    pending;
  int    checked;
  int    sent = 0;
  int    cycle_count = 0;
  bit    no_idle = 1'b0;
  bit    rst_done = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  seed_to_key_shift_xor DUT (
    .clk        (clk),
    .rst        (rst),
    .seed_valid (seed_valid),
    .seed_ready (seed_ready),
    .seed       (seed),
    .key_valid  (key_valid),
    .key_ready  (key_ready),
    .key        (key)
  );

  seed_to_key_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .seed_valid (seed_valid),
    .seed_ready (seed_ready),
    .seed       (seed),
    .key_valid  (key_valid),
    .key_ready  (key_ready),
    .key        (key),
    .errors     (errors),
    .pending    (pending),
    .checked    (checked)
  );

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("[%0t] timeout with %0d keys outstanding", $realtime, pending);
    $display("seed_to_key_shift_xor_test: done, errors");
    $finish;
  end

  // key side: random stall before each beat, none during burst blocks
  initial begin
    int stall;
    wait (rst_done);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        key_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      key_ready <= 1'b1;
      @(posedge clk);
      while (!(key_valid && key_ready)) @(posedge clk);
    end
  end

  // drives one seed beat starting at the current edge; the gap before the next beat
  // is taken after acceptance so valid is never dropped and raised in one step
  task automatic send_seed(input word_t s);
    int gap;
    seed       <= s;
    seed_valid <= 1'b1;
    @(posedge clk);
    while (!seed_ready) @(posedge clk);
    sent++;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      seed_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // places a 4-bit table select on seed bits 0, 1, 2, 9 over a given fill
  function automatic word_t with_select(input logic [3:0] sel, input word_t fill);
    word_t s;
    s    = fill & ~32'h0000_0207;
    s[0] = sel[3];
    s[1] = sel[2];
    s[2] = sel[1];
    s[9] = sel[0];
    return s;
  endfunction

  function automatic word_t random_seed();
    word_t s;
    case ($urandom_range(0, 9))
      0: s = 32'h1 << $urandom_range(0, 31);
      1: s = ~(32'h1 << $urandom_range(0, 31));
      2: s = $urandom & ~32'h0000_0A27;    // fewest steps
      3: s = $urandom | 32'h0000_0A27;     // most steps
      4: s = $urandom | 32'h8000_0000;
      5: s = $urandom & $urandom & $urandom;
      default: s = $urandom;
    endcase
    return s;
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    rst      <= 1'b0;
    rst_done  = 1'b1;
    @(posedge clk);

    send_seed(32'h0000_0000);
    send_seed(32'hFFFF_FFFF);
    send_seed(32'h0000_0A27);
    send_seed(32'hFFFF_F5D8);
    send_seed(32'h8000_0000);
    send_seed(32'h0000_0001);
    send_seed(32'h5555_5555);
    send_seed(32'hAAAA_AAAA);
    for (int i = 0; i < 16; i++) begin
      send_seed(with_select(4'(i), (i % 2) ? 32'hC000_0000 | $urandom : $urandom));
    end

    for (int n = 0; n < RandomSeeds; n++) begin
      no_idle = ((n / BlockLen) % 3) == 2;
      send_seed(random_seed());
    end
    seed_valid <= 1'b0;
    no_idle     = 1'b0;

    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk);

    $display("sent %0d seeds over both step-count extremes and all 16 table selects",
             sent);
    $display("checker compared %0d keys under random gaps, stalls and burst blocks",
             checked);
    if (errors == 0 && pending == 0) begin
      $display("seed_to_key_shift_xor_test: done, clean");
    end else begin
      $display("seed_to_key_shift_xor_test: done, errors");
    end
    $finish;
  end

endmodule
